FILE: design/psu_pkg.sv
`default_nettype none

package psu_pkg;

  // one input word: a filter type or a filtered data byte
  typedef struct packed {
    logic [7:0] raw_byte;
    logic       image_start;
  } in_word_t;

  // one result word: a reconstructed data byte
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
  } out_word_t;

  // classified data byte, handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] filter;
    logic [2:0] bpp_idx;
    logic       first_row;
    logic       row_start;
    logic       last;
  } item_meta_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;

  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  localparam int HIST_DEPTH  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W = 3;

  // paeth predictor: pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0] pa;
    logic [10:0] pb;
    logic [10:0] pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/png_scanline_unfilter_top.sv
// png scanline unfilter: rebuilds filtered png rows one byte per clock when not stalled
// input side is a queue: present in_word with push, a word is taken on a
// clock edge with push high and full low; the first byte of each row is its
// filter type (none, sub, up, average, paeth; higher codes act as none) and
// gives no result, image_start marks the filter byte of a new image's first row
// result side is a queue: while empty is low, out_word holds the oldest
// result, and it is taken on an edge with pop high
// config words (row_bytes, bytes_per_pixel) go over cfg_valid/cfg_index/
// cfg_data; cfg_ready is always high, write only while the block is idle
// throughput: one byte per clock while the result side keeps up, set by the
// single reconstruct stage that reads the left neighbor written by the byte just before it
// the line store keeps the previous row; a read that hits the column being
// written in the same cycle is forwarded around the ram
// reset clears control state and loads row_bytes = 1, bytes_per_pixel = 1;
// the line store has no clearing pass, the first row of an image reads zeros
// when pop stays low the result queue fills, the back end stops issuing,
// the middle queue fills and full rises; no word is lost or repeated
`default_nettype none

module png_scanline_unfilter_top import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input word queue
  input  wire logic                   push,
  input  wire in_word_t               in_word,
  output logic                        full,
  // result word queue
  input  wire logic                   pop,
  output out_word_t                   out_word,
  output logic                        empty,
  // config write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW     = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int MQ_W   = CW + $bits(item_meta_t);

  // front to middle queue
  logic          mq_push;
  logic [CW-1:0] fr_col;
  item_meta_t    fr_meta;
  logic          mq_full;
  // middle queue to back
  logic            mq_pop;
  logic            mq_empty;
  logic [MQ_W-1:0] mq_head;
  logic [CW-1:0]   bk_col;
  item_meta_t      bk_meta;
  // back to result queue
  logic                   oq_push;
  out_word_t              oq_word;
  logic [QUEUE_CNT_W-1:0] oq_count;
  logic                   oq_full;

  assign cfg_ready = 1'b1;
  assign full      = mq_full;

  // classify bytes: filter type vs data, track column and row state
  psu_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_push   (push),
    .in_word   (in_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_full   (mq_full),
    .mq_push   (mq_push),
    .mq_col    (fr_col),
    .mq_meta   (fr_meta)
  );

  // short queue of classified data bytes between front and back
  psu_fifo #(
    .WIDTH (MQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mq_push),
    .wr_data ({fr_col, fr_meta}),
    .full    (mq_full),
    .pop     (mq_pop),
    .empty   (mq_empty),
    .rd_data (mq_head),
    .count   ()
  );

  assign bk_col  = mq_head[MQ_W-1 -: CW];
  assign bk_meta = item_meta_t'(mq_head[$bits(item_meta_t)-1:0]);

  // line store read, neighbor selection, reconstruction
  psu_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_empty (mq_empty),
    .mq_col   (bk_col),
    .mq_meta  (bk_meta),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_word  (oq_word)
  );

  // result queue; back end never pushes into a full queue
  psu_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (oq_push && !oq_full),
    .wr_data (oq_word),
    .full    (oq_full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (out_word),
    .count   (oq_count)
  );

endmodule

`default_nettype wire

FILE: design/psu_ram.sv
`default_nettype none

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/psu_fifo.sv
`default_nettype none

module psu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wr_data,
  output logic                              full,
  input  wire logic                         pop,
  output logic                              empty,
  output logic      [WIDTH-1:0]             rd_data,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/psu_front.sv
`default_nettype none

module psu_front import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          in_push,
  input  wire in_word_t                                      in_word,
  input  wire logic                                          cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0]                        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                         cfg_data,
  input  wire logic                                          mq_full,
  output logic                                               mq_push,
  output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0] mq_col,
  output item_meta_t                                         mq_meta
);

  localparam int CW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CLW = $clog2(MAX_ROW_BYTES + 1);
  localparam int LW  = ((CLW > CFG_DATA_W) ? CLW : CFG_DATA_W) + 1;

  logic [CFG_DATA_W-1:0] row_bytes;
  logic [3:0]            bytes_per_pixel;
  logic [CW-1:0]         col;
  logic [7:0]            row_filter;
  logic                  awaiting;
  logic                  first_row;

  logic          accept;
  logic          filter_byte;
  logic          last;
  logic [LW-1:0] rb_ext;
  logic [LW-1:0] rlen;
  logic [3:0]    bpp_eff;

  assign accept      = in_push && !mq_full;
  assign filter_byte = in_word.image_start || awaiting;
  assign mq_push     = accept && !filter_byte;
  assign mq_col      = col;

  // clamp row length into 1..MAX_ROW_BYTES
  always_comb begin
    rb_ext = LW'(row_bytes);
    if (rb_ext == '0) begin
      rlen = LW'(1);
    end else if (rb_ext > LW'(MAX_ROW_BYTES)) begin
      rlen = LW'(MAX_ROW_BYTES);
    end else begin
      rlen = rb_ext;
    end
  end

  // clamp pixel size into 1..MAX_PIXEL_BYTES
  always_comb begin
    if (bytes_per_pixel == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bytes_per_pixel > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign last = ((LW'(col) + LW'(1)) >= rlen);

  always_comb begin
    mq_meta.data      = in_word.raw_byte;
    mq_meta.filter    = row_filter;
    mq_meta.bpp_idx   = 3'(bpp_eff - 4'd1);
    mq_meta.first_row = first_row;
    mq_meta.row_start = (col == '0);
    mq_meta.last      = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= CFG_DATA_W'(1);
      bytes_per_pixel <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_BYTES: begin
          row_bytes <= cfg_data;
        end
        REG_BYTES_PER_PIXEL: begin
          bytes_per_pixel <= cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row_filter <= '0;
      awaiting   <= 1'b1;
      first_row  <= 1'b1;
    end else if (accept) begin
      if (filter_byte) begin
        row_filter <= in_word.raw_byte;
        awaiting   <= 1'b0;
        col        <= '0;
        if (in_word.image_start) begin
          first_row <= 1'b1;
        end
      end else if (last) begin
        awaiting  <= 1'b1;
        first_row <= 1'b0;
        col       <= '0;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/psu_back.sv
`default_nettype none

module psu_back import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          mq_empty,
  input  wire logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0] mq_col,
  input  wire item_meta_t                                    mq_meta,
  output logic                                               mq_pop,
  input  wire logic [QUEUE_CNT_W-1:0]                        oq_count,
  output logic                                               oq_push,
  output out_word_t                                          oq_word
);

  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  logic          s1_valid;
  item_meta_t    s1_meta;
  logic [CW-1:0] s1_col;
  logic          s1_byp;
  logic [7:0]    s1_byp_data;

  logic [7:0] left_hist [HIST_DEPTH];
  logic [7:0] up_hist   [HIST_DEPTH];
  logic [7:0] left_eff  [HIST_DEPTH];
  logic [7:0] up_eff    [HIST_DEPTH];

  logic       issue;
  logic       byp_hit;
  logic [7:0] ram_rdata;
  logic [7:0] up_raw;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] ab_sum;
  logic [7:0] pred;
  logic [7:0] v;

  // only issue when the result queue has room for everything in flight
  assign issue   = !mq_empty && ((oq_count + QUEUE_CNT_W'(s1_valid)) < QUEUE_CNT_W'(QUEUE_DEPTH));
  assign mq_pop  = issue;
  // same column written this cycle: ram returns old data, so forward
  assign byp_hit = s1_valid && (s1_col == mq_col);

  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (v),
    .re    (issue),
    .raddr (mq_col),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_eff[i] = s1_meta.row_start ? 8'd0 : left_hist[i];
      up_eff[i]   = s1_meta.row_start ? 8'd0 : up_hist[i];
    end
    up_raw = s1_byp ? s1_byp_data : ram_rdata;
    b      = s1_meta.first_row ? 8'd0 : up_raw;
    a      = left_eff[s1_meta.bpp_idx];
    c      = up_eff[s1_meta.bpp_idx];
    ab_sum = {1'b0, a} + {1'b0, b};
    case (s1_meta.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    v = s1_meta.data + pred;
  end

  assign oq_push            = s1_valid;
  assign oq_word.pixel_byte = v;
  assign oq_word.row_end    = s1_meta.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta     <= mq_meta;
      s1_col      <= mq_col;
      s1_byp      <= byp_hit;
      s1_byp_data <= v;
    end
  end

  // newest first; cleared at the start of each row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        left_hist[i] <= '0;
        up_hist[i]   <= '0;
      end
    end else if (s1_valid) begin
      left_hist[0] <= v;
      up_hist[0]   <= b;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        left_hist[i] <= left_eff[i-1];
        up_hist[i]   <= up_eff[i-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_png_scanline_unfilter_top.sv
`default_nettype none

import psu_pkg::*;

// tracks the unfilter state and holds the rebuilt bytes still owed by the block
class unfilter_scoreboard;
  localparam int LINE_DEPTH = 8192;
  localparam int PIX_MAX    = 8;

  logic [13:0]  row_bytes_reg;
  logic [3:0]   bpp_reg;
  logic [7:0]   line_store [LINE_DEPTH];
  logic [7:0]   left_hist [PIX_MAX];
  logic [7:0]   up_hist [PIX_MAX];
  int unsigned  col_pos;
  logic [7:0]   filt;
  bit           want_filter;
  bit           first_row;
  int unsigned  store_hi;
  out_word_t    pending [$];
  int unsigned  n_in;
  int unsigned  n_out;
  int unsigned  errors;

  function new();
    row_bytes_reg = 14'd1;
    bpp_reg       = 4'd1;
    foreach (left_hist[i]) left_hist[i] = '0;
    foreach (up_hist[i]) up_hist[i] = '0;
    col_pos     = 0;
    filt        = '0;
    want_filter = 1'b1;
    first_row   = 1'b1;
    store_hi    = 0;
    n_in        = 0;
    n_out       = 0;
    errors      = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    if (idx == REG_ROW_BYTES) begin
      row_bytes_reg = d;
    end else if (idx == REG_BYTES_PER_PIXEL) begin
      bpp_reg = d[3:0];
    end
  endfunction

  function int unsigned row_len();
    int unsigned r;
    r = row_bytes_reg;
    if (r == 0) r = 1;
    if (r > LINE_DEPTH) r = LINE_DEPTH;
    return r;
  endfunction

  function int unsigned pix_len();
    int unsigned p;
    p = bpp_reg;
    if (p == 0) p = 1;
    if (p > PIX_MAX) p = PIX_MAX;
    return p;
  endfunction

  // a data word on a later row past every column ever stored
  function bit needs_fresh_image(bit start);
    return !start && !want_filter && !first_row && (col_pos >= store_hi);
  endfunction

  function int unsigned pick_paeth(int a, int b, int c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function void note_word(in_word_t w);
    int unsigned len;
    int unsigned pix;
    int unsigned col;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned v;
    out_word_t   e;
    n_in++;
    len = row_len();
    pix = pix_len();
    if (w.image_start) first_row = 1'b1;
    if (w.image_start || want_filter) begin
      filt        = w.raw_byte;
      want_filter = 1'b0;
      col_pos     = 0;
      foreach (left_hist[i]) left_hist[i] = '0;
      foreach (up_hist[i]) up_hist[i] = '0;
      return;
    end
    col = col_pos;
    if (col >= LINE_DEPTH) col = LINE_DEPTH - 1;
    a = (col >= pix) ? left_hist[pix-1] : 0;
    b = first_row ? 0 : line_store[col];
    c = (col >= pix) ? up_hist[pix-1] : 0;
    v = w.raw_byte;
    case (filt)
      FILT_SUB:   v += a;
      FILT_UP:    v += b;
      FILT_AVG:   v += (a + b) >> 1;
      FILT_PAETH: v += pick_paeth(a, b, c);
      default:    ;
    endcase
    line_store[col] = 8'(v);
    if (col + 1 > store_hi) store_hi = col + 1;
    for (int i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      up_hist[i]   = up_hist[i-1];
    end
    left_hist[0] = 8'(v);
    up_hist[0]   = 8'(b);
    e.pixel_byte = 8'(v);
    e.row_end    = (col + 1 >= len);
    if (e.row_end) begin
      want_filter = 1'b1;
      first_row   = 1'b0;
      col_pos     = 0;
    end else begin
      col_pos = col + 1;
    end
    pending.push_back(e);
  endfunction

  function void check_word(out_word_t got);
    out_word_t e;
    if (pending.size() == 0) begin
      $error("result with nothing expected: pixel_byte %0d row_end %0d",
             got.pixel_byte, got.row_end);
      errors++;
      return;
    end
    e = pending.pop_front();
    n_out++;
    if (got.pixel_byte !== e.pixel_byte) begin
      $error("pixel_byte mismatch: expected %0d, actual %0d", e.pixel_byte, got.pixel_byte);
      errors++;
    end
    if (got.row_end !== e.row_end) begin
      $error("row_end mismatch: expected %0d, actual %0d", e.row_end, got.row_end);
      errors++;
    end
  endfunction
endclass

module tb_png_scanline_unfilter_top;

  localparam int RANDOM_WORDS = 420;
  // settle time after the last owed result, covers filter words in flight
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_WORDS    = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  in_word_t               in_word = '0;
  logic                   full;
  logic                   pop = 1'b0;
  out_word_t              out_word;
  logic                   empty;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  unfilter_scoreboard sb;

  // idle odds per side, changed from phase to phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // set by the sender to make the receiver hold pop low for a long stretch
  bit          rx_hold_req = 1'b0;
  int unsigned full_stalls = 0;
  int unsigned phase_count = 0;

  png_scanline_unfilter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .pop       (pop),
    .out_word  (out_word),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // safety limit, far above the slowest legal run
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // cycles where the block refuses an offered word
  always @(posedge clk) begin
    if (!rst && push && full) full_stalls <= full_stalls + 1;
  end

  function automatic int unsigned draw_gap(int unsigned pct);
    if ($urandom_range(99) < pct) return $urandom_range(15);
    return 0;
  endfunction

  // offer one word and wait until an edge takes it; push stays high afterwards
  // so a back-to-back word does not drop and raise it in one step
  task automatic send_word(logic [7:0] d, bit start);
    int unsigned gap;
    // never let a later row read a line store column that was never written
    if (sb.needs_fresh_image(start)) start = 1'b1;
    gap = draw_gap(tx_idle_pct);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_word <= '{raw_byte: d, image_start: start};
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    sb.note_word('{raw_byte: d, image_start: start});
  endtask

  // mostly well-formed rows: filter codes on filter words, random data,
  // with a little image_start noise that cuts rows short
  task automatic send_random_word(bit start);
    logic [7:0] d;
    if (!start) start = ($urandom_range(99) < 2);
    if (start || sb.want_filter) begin
      d = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
    end else begin
      d = 8'($urandom);
    end
    send_word(d, start);
  endtask

  // stop offering and wait for every owed result, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // each write ends with valid dropped, so valid is low between two writes
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  // result side: random gaps, an occasional long hold, check every popped word
  initial begin : result_side
    int unsigned gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(rx_idle_pct);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk);
        if (!empty) break;
      end
      sb.check_word(out_word);
    end
  end

  initial begin : main_seq
    int unsigned target;
    int unsigned n;
    int unsigned rb;
    int unsigned waited;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two-byte rows, one of each filter, extreme data values
    write_reg(REG_ROW_BYTES, 14'd2);
    write_reg(REG_BYTES_PER_PIXEL, 14'd1);
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(FILT_SUB, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(FILT_UP, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd1, 1'b0);
    send_word(FILT_AVG, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(FILT_PAETH, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd255, 1'b0);
    // unknown filter code acts as none, then a new image cuts the row
    send_word(8'd255, 1'b0);
    send_word(8'd9, 1'b0);
    send_word(FILT_PAETH, 1'b1);
    send_word(8'd200, 1'b0);
    send_word(8'd100, 1'b0);

    // zero row length and zero pixel size act as one
    drain();
    write_reg(REG_ROW_BYTES, 14'd0);
    write_reg(REG_BYTES_PER_PIXEL, 14'd0);
    send_word(FILT_SUB, 1'b0);
    send_word(8'd77, 1'b0);

    // oversized pixel size, then the row shrinks under a half-sent row
    drain();
    write_reg(REG_ROW_BYTES, 14'd6);
    write_reg(REG_BYTES_PER_PIXEL, 14'd15);
    send_word(FILT_PAETH, 1'b1);
    repeat (4) send_word(8'($urandom), 1'b0);
    drain();
    write_reg(REG_ROW_BYTES, 14'd2);
    send_word(8'($urandom), 1'b0);
    send_word(FILT_AVG, 1'b0);
    repeat (2) send_word(8'($urandom), 1'b0);

    // random phases: each one a new setting, idle mix and image choice
    target = sb.n_in + RANDOM_WORDS;
    while (sb.n_in < target) begin
      drain();
      case ($urandom_range(9))
        0:       rb = 0;
        1:       rb = 1;
        2:       rb = $urandom_range(100, 300);
        default: rb = $urandom_range(2, 24);
      endcase
      write_reg(REG_ROW_BYTES, 14'(rb));
      write_reg(REG_BYTES_PER_PIXEL, 14'($urandom_range(15)));
      case ($urandom_range(2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 20;
        default: tx_idle_pct = 70;
      endcase
      case ($urandom_range(2))
        0:       rx_idle_pct = 0;
        1:       rx_idle_pct = 20;
        default: rx_idle_pct = 70;
      endcase
      // one phase runs the sender flat out into a stalled receiver
      if (phase_count == 2) begin
        tx_idle_pct = 0;
        rx_hold_req = 1'b1;
      end
      n = $urandom_range(20, 60);
      send_random_word($urandom_range(1) == 1);
      for (int k = 1; k < n; k++) begin
        // sometimes pause mid-stream, let all results out and retune the row
        if (k == n / 2 && $urandom_range(3) == 0) begin
          drain();
          write_reg(REG_ROW_BYTES, 14'($urandom_range(1, 24)));
        end
        send_random_word(1'b0);
      end
      phase_count++;
    end

    // oversized row length acts as the largest row, rows cut by new images
    drain();
    write_reg(REG_ROW_BYTES, 14'h3fff);
    write_reg(REG_BYTES_PER_PIXEL, 14'd8);
    tx_idle_pct = 2;
    rx_idle_pct = 10;
    send_word(FILT_SUB, 1'b1);
    repeat (TAIL_WORDS) send_word(8'($urandom), 1'b0);
    send_word(FILT_PAETH, 1'b1);
    repeat (TAIL_WORDS) send_word(8'($urandom), 1'b0);

    // wind down: wait for the last results, then let the pipe settle
    push <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input words and %0d results over %0d random phases,",
             sb.n_in, sb.n_out, phase_count);
    $display("with %0d cycles of input held off by a full block", full_stalls);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
